>>> src/mcc_pkg.sv
// shared types and constants for the midi channel controller
// no dependencies
package mcc_pkg;

  typedef enum logic [3:0] {
    CMD_PROGRAM     = 4'd0,
    CMD_VOLUME      = 4'd1,
    CMD_EXPRESSION  = 4'd2,
    CMD_PITCHWHEEL  = 4'd3,
    CMD_BANK_LSB    = 4'd4,
    CMD_BANK_MSB    = 4'd5,
    CMD_DATA_LSB    = 4'd6,
    CMD_DATA_MSB    = 4'd7,
    CMD_DATA_INC    = 4'd8,
    CMD_DATA_DEC    = 4'd9,
    CMD_NRPN_LSB    = 4'd10,
    CMD_NRPN_MSB    = 4'd11,
    CMD_RPN_LSB     = 4'd12,
    CMD_RPN_MSB     = 4'd13,
    CMD_RESET_ALL   = 4'd14
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_t;

  localparam logic [13:0] NULL_NUMBER   = 14'h3FFF;
  localparam logic [13:0] RANGE_DEFAULT = 14'd256;
  localparam logic [7:0]  FULL_SCALE    = 8'h80;
  localparam logic [6:0]  EXPR_RESET    = 7'h7F;
  localparam logic [13:0] RPN_RANGE     = 14'h0000;
  localparam logic [13:0] RPN_FINE      = 14'h0001;
  localparam logic [13:0] RPN_COARSE    = 14'h0002;
  localparam logic [13:0] NRPN_RANGE    = 14'h0011;
  localparam logic [13:0] NRPN_VOLUME   = 14'h0020;
  localparam logic [13:0] NRPN_FINE     = 14'h0021;
  localparam logic [13:0] NRPN_COARSE   = 14'h0022;

  // commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       walk;
    logic       mul;
    logic       wb;
    logic       load_out;
    logic [3:0] walk_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic reset_all;
  } dp_status_t;

endpackage

>>> src/mcc_if.sv
// handshake channels for messages and results
// payload widths fixed by the message format
interface mcc_msg_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [3:0] channel;
  logic [6:0] data_msb;
  logic [6:0] data_lsb;
  modport source (output valid, command, channel, data_msb, data_lsb, input ready);
  modport sink (input valid, command, channel, data_msb, data_lsb, output ready);
endinterface

interface mcc_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_channel;
  logic [7:0]         level;
  logic signed [15:0] pitch_offset;
  logic [6:0]         program_number;
  logic [13:0]        bank_number;
  logic               program_changed;
  logic               chip_param_valid;
  logic [13:0]        chip_param_type;
  logic [13:0]        chip_param_value;
  modport source (output valid, out_channel, level, pitch_offset, program_number,
                  bank_number, program_changed, chip_param_valid, chip_param_type,
                  chip_param_value, input ready);
  modport sink (input valid, out_channel, level, pitch_offset, program_number,
                bank_number, program_changed, chip_param_valid, chip_param_type,
                chip_param_value, output ready);
endinterface

>>> src/mcc_ctrl.sv
// sequencer for the channel controller: message capture, recalc steps, reset-all walk
// depends on mcc_pkg
module mcc_ctrl #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mcc_pkg::dp_status_t status,
  output mcc_pkg::dp_cmd_t    cmd
);

  mcc_pkg::state_t state, state_next;
  logic [3:0] walk_idx, walk_idx_next;
  logic       out_valid_next;
  logic       walk_last;

  assign walk_last = (walk_idx == 4'(NUM_CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcc_pkg::ST_IDLE;
      walk_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      walk_idx  <= walk_idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    walk_idx_next  = walk_idx;
    out_valid_next = out_valid;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.walk_idx   = walk_idx;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    case (state)
      mcc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = mcc_pkg::ST_EXEC;
        end
      end
      mcc_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        walk_idx_next = '0;
        state_next    = status.reset_all ? mcc_pkg::ST_WALK : mcc_pkg::ST_MUL;
      end
      mcc_pkg::ST_WALK: begin
        cmd.walk   = 1'b1;
        state_next = mcc_pkg::ST_MUL;
      end
      mcc_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = mcc_pkg::ST_WB;
      end
      mcc_pkg::ST_WB: begin
        cmd.wb = 1'b1;
        if (status.reset_all && !walk_last) begin
          walk_idx_next = walk_idx + 4'd1;
          state_next    = mcc_pkg::ST_WALK;
        end else begin
          state_next = mcc_pkg::ST_DONE;
        end
      end
      mcc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = mcc_pkg::ST_IDLE;
        end
      end
      default: state_next = mcc_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/mcc_dp.sv
// per-channel stores, data entry decode, level and pitch recalculation, result register
// depends on mcc_pkg
module mcc_dp #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  mcc_pkg::dp_cmd_t    cmd,
  output mcc_pkg::dp_status_t status,
  input  logic [3:0]          in_command,
  input  logic [3:0]          in_channel,
  input  logic [6:0]          in_d1,
  input  logic [6:0]          in_d2,
  output logic [3:0]          out_channel,
  output logic [7:0]          level,
  output logic signed [15:0]  pitch_offset,
  output logic [6:0]          program_number,
  output logic [13:0]         bank_number,
  output logic                program_changed,
  output logic                chip_param_valid,
  output logic [13:0]         chip_param_type,
  output logic [13:0]         chip_param_value
);

  localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [6:0]         program_store      [NUM_CHANNELS];
  logic [13:0]        bank_store         [NUM_CHANNELS];
  logic [13:0]        registered_number  [NUM_CHANNELS];
  logic [13:0]        unregistered_number[NUM_CHANNELS];
  logic [13:0]        entry_data         [NUM_CHANNELS];
  logic [7:0]         volume_store       [NUM_CHANNELS];
  logic [7:0]         expression_store   [NUM_CHANNELS];
  logic [7:0]         level_store        [NUM_CHANNELS];
  logic signed [14:0] wheel_store        [NUM_CHANNELS];
  logic signed [6:0]  coarse_store       [NUM_CHANNELS];
  logic signed [14:0] fine_store         [NUM_CHANNELS];
  logic [15:0]        pitch_store        [NUM_CHANNELS];
  logic [13:0]        bend_range_store   [NUM_CHANNELS];
  logic [7:0]         instr_volume_store [NUM_CHANNELS];
  logic signed [7:0]  instr_coarse_store [NUM_CHANNELS];
  logic signed [14:0] instr_fine_store   [NUM_CHANNELS];

  mcc_pkg::cmd_t cur_cmd;
  logic [3:0]    cur_chan;
  logic [6:0]    cur_d1, cur_d2;
  logic          ok;
  logic [IW-1:0] sel, rc;
  logic          do_level, do_pitch;
  logic          changed, fv;
  logic [13:0]   ft, fval;
  logic [15:0]        prod_lv;
  logic signed [29:0] prod_wh;

  logic [13:0]        e_old, e_new, sw;
  logic signed [14:0] tune, fine_val, ifine_val, wt, wheel_val;
  logic signed [7:0]  crs;
  logic [7:0]         ivol_val, byte_val;
  logic [16:0]        lv_prod;
  logic signed [29:0] wh_shift;
  logic signed [15:0] fine16, ifine16;
  logic [15:0]        pitch_sum;

  assign ok = ({1'b0, cur_chan} < 5'(NUM_CHANNELS));
  assign status.reset_all = (cur_cmd == mcc_pkg::CMD_RESET_ALL);

  always_comb begin
    sel   = cmd.walk ? cmd.walk_idx[IW-1:0] : cur_chan[IW-1:0];
    e_old = entry_data[sel];
    case (cur_cmd)
      mcc_pkg::CMD_DATA_LSB: e_new = {e_old[13:7], cur_d1};
      mcc_pkg::CMD_DATA_MSB: e_new = {cur_d1, e_old[6:0]};
      mcc_pkg::CMD_DATA_INC: e_new = (e_old != 14'h3FFF) ? e_old + 14'd1 : e_old;
      mcc_pkg::CMD_DATA_DEC: e_new = (e_old != 14'h0000) ? e_old - 14'd1 : e_old;
      default:               e_new = e_old;
    endcase
    // parameter data arrives byte-swapped: low 7 bits act as msb
    sw        = {e_new[6:0], e_new[13:7]};
    tune      = $signed({1'b0, sw}) - 15'sd8192;
    fine_val  = (tune > 15'sd0) ? tune + 15'sd1 : tune;
    ifine_val = (tune != 15'sd0) ? tune + 15'sd1 : tune;
    crs       = $signed({1'b0, e_new[13:7]}) - 8'sd64;
    ivol_val  = (e_new[13:7] == 7'd0) ? 8'd0 : {1'b0, e_new[13:7]} + 8'd1;
    wt        = $signed({1'b0, cur_d1, cur_d2}) - 15'sd8192;
    wheel_val = (wt > 15'sd0) ? wt + 15'sd1 : wt;
    byte_val  = (cur_d1 == 7'd0) ? 8'd0 : {1'b0, cur_d1} + 8'd1;
    // second level multiply feeds the store directly
    lv_prod   = 17'(prod_lv[15:7] * instr_volume_store[rc]);
    wh_shift  = prod_wh >>> 13;
    fine16    = $signed({fine_store[rc][14], fine_store[rc]}) >>> 6;
    ifine16   = $signed({instr_fine_store[rc][14], instr_fine_store[rc]}) >>> 6;
    pitch_sum = wh_shift[15:0]
              + {{2{coarse_store[rc][6]}}, coarse_store[rc], 7'd0}
              + fine16
              + {instr_coarse_store[rc][7], instr_coarse_store[rc], 7'd0}
              + ifine16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        program_store[i]       <= '0;
        bank_store[i]          <= '0;
        registered_number[i]   <= mcc_pkg::NULL_NUMBER;
        unregistered_number[i] <= mcc_pkg::NULL_NUMBER;
        entry_data[i]          <= '0;
        volume_store[i]        <= mcc_pkg::FULL_SCALE;
        expression_store[i]    <= mcc_pkg::FULL_SCALE;
        level_store[i]         <= mcc_pkg::FULL_SCALE;
        wheel_store[i]         <= '0;
        coarse_store[i]        <= '0;
        fine_store[i]          <= '0;
        pitch_store[i]         <= '0;
        bend_range_store[i]    <= mcc_pkg::RANGE_DEFAULT;
        instr_volume_store[i]  <= mcc_pkg::FULL_SCALE;
        instr_coarse_store[i]  <= '0;
        instr_fine_store[i]    <= '0;
      end
      cur_cmd  <= mcc_pkg::CMD_PROGRAM;
      do_level <= 1'b0;
      do_pitch <= 1'b0;
      changed  <= 1'b0;
      fv       <= 1'b0;
    end else begin
      if (cmd.capture) begin
        cur_cmd  <= mcc_pkg::cmd_t'(in_command);
        cur_chan <= in_channel;
        cur_d1   <= in_d1;
        cur_d2   <= in_d2;
      end
      if (cmd.exec) begin
        rc       <= sel;
        do_level <= 1'b0;
        do_pitch <= 1'b0;
        changed  <= 1'b0;
        fv       <= 1'b0;
        ft       <= '0;
        fval     <= '0;
        if (ok) begin
          case (cur_cmd)
            mcc_pkg::CMD_PROGRAM: begin
              if (program_store[sel] != cur_d1) begin
                program_store[sel]      <= cur_d1;
                bend_range_store[sel]   <= mcc_pkg::RANGE_DEFAULT;
                instr_volume_store[sel] <= mcc_pkg::FULL_SCALE;
                instr_coarse_store[sel] <= '0;
                instr_fine_store[sel]   <= '0;
                changed                 <= 1'b1;
              end
            end
            mcc_pkg::CMD_VOLUME: begin
              if (volume_store[sel] != {1'b0, cur_d1}) begin
                volume_store[sel] <= byte_val;
                do_level          <= 1'b1;
              end
            end
            mcc_pkg::CMD_EXPRESSION: begin
              if (expression_store[sel] != {1'b0, cur_d1}) begin
                expression_store[sel] <= byte_val;
                do_level              <= 1'b1;
              end
            end
            mcc_pkg::CMD_PITCHWHEEL: begin
              wheel_store[sel] <= wheel_val;
              do_pitch         <= 1'b1;
            end
            mcc_pkg::CMD_BANK_LSB: bank_store[sel] <= {bank_store[sel][13:7], cur_d1};
            mcc_pkg::CMD_BANK_MSB: bank_store[sel] <= {cur_d1, bank_store[sel][6:0]};
            mcc_pkg::CMD_DATA_LSB, mcc_pkg::CMD_DATA_MSB,
            mcc_pkg::CMD_DATA_INC, mcc_pkg::CMD_DATA_DEC: begin
              entry_data[sel] <= e_new;
              if (registered_number[sel] != mcc_pkg::NULL_NUMBER) begin
                if (registered_number[sel] == mcc_pkg::RPN_RANGE) begin
                  if (bend_range_store[sel] != sw) begin
                    bend_range_store[sel] <= sw;
                    do_pitch              <= 1'b1;
                  end
                end else if (registered_number[sel] == mcc_pkg::RPN_FINE) begin
                  fine_store[sel] <= fine_val;
                  do_pitch        <= 1'b1;
                end else if (registered_number[sel] == mcc_pkg::RPN_COARSE) begin
                  coarse_store[sel] <= crs[6:0];
                  do_pitch          <= 1'b1;
                end
              end else if (unregistered_number[sel] != mcc_pkg::NULL_NUMBER) begin
                if (unregistered_number[sel] == mcc_pkg::NRPN_RANGE) begin
                  if (bend_range_store[sel] != sw) begin
                    bend_range_store[sel] <= sw;
                    do_pitch              <= 1'b1;
                  end
                end else if (unregistered_number[sel] == mcc_pkg::NRPN_VOLUME) begin
                  if (instr_volume_store[sel] != ivol_val) begin
                    instr_volume_store[sel] <= ivol_val;
                    do_level                <= 1'b1;
                  end
                end else if (unregistered_number[sel] == mcc_pkg::NRPN_FINE) begin
                  if (instr_fine_store[sel] != ifine_val) begin
                    instr_fine_store[sel] <= ifine_val;
                    do_pitch              <= 1'b1;
                  end
                end else if (unregistered_number[sel] == mcc_pkg::NRPN_COARSE) begin
                  if (instr_coarse_store[sel] != crs) begin
                    instr_coarse_store[sel] <= crs;
                    do_pitch                <= 1'b1;
                  end
                end else begin
                  fv   <= 1'b1;
                  ft   <= unregistered_number[sel];
                  fval <= e_new;
                end
              end
            end
            mcc_pkg::CMD_NRPN_LSB: begin
              registered_number[sel]   <= mcc_pkg::NULL_NUMBER;
              unregistered_number[sel] <= {unregistered_number[sel][13:7], cur_d1};
            end
            mcc_pkg::CMD_NRPN_MSB: begin
              registered_number[sel]   <= mcc_pkg::NULL_NUMBER;
              unregistered_number[sel] <= {cur_d1, unregistered_number[sel][6:0]};
            end
            mcc_pkg::CMD_RPN_LSB: begin
              unregistered_number[sel] <= mcc_pkg::NULL_NUMBER;
              registered_number[sel]   <= {registered_number[sel][13:7], cur_d1};
            end
            mcc_pkg::CMD_RPN_MSB: begin
              unregistered_number[sel] <= mcc_pkg::NULL_NUMBER;
              registered_number[sel]   <= {cur_d1, registered_number[sel][6:0]};
            end
            default: ;
          endcase
        end
      end
      if (cmd.walk) begin
        // reset all controllers on one channel
        rc       <= sel;
        do_level <= 1'b0;
        if (expression_store[sel] != {1'b0, mcc_pkg::EXPR_RESET}) begin
          expression_store[sel] <= mcc_pkg::FULL_SCALE;
          do_level              <= 1'b1;
        end
        wheel_store[sel]         <= '0;
        do_pitch                 <= 1'b1;
        registered_number[sel]   <= mcc_pkg::NULL_NUMBER;
        unregistered_number[sel] <= mcc_pkg::NULL_NUMBER;
      end
      if (cmd.mul) begin
        prod_lv <= volume_store[rc] * expression_store[rc];
        prod_wh <= wheel_store[rc] * $signed({1'b0, bend_range_store[rc]});
      end
      if (cmd.wb) begin
        if (do_level) level_store[rc] <= lv_prod[14:7];
        if (do_pitch) pitch_store[rc] <= pitch_sum;
      end
      if (cmd.load_out) begin
        out_channel      <= cur_chan;
        level            <= ok ? level_store[cur_chan[IW-1:0]] : 8'd0;
        pitch_offset     <= ok ? $signed(pitch_store[cur_chan[IW-1:0]]) : 16'sd0;
        program_number   <= ok ? program_store[cur_chan[IW-1:0]] : 7'd0;
        bank_number      <= ok ? bank_store[cur_chan[IW-1:0]] : 14'd0;
        program_changed  <= changed;
        chip_param_valid <= fv;
        chip_param_type  <= fv ? ft : 14'd0;
        chip_param_value <= fv ? fval : 14'd0;
      end
    end
  end

endmodule

>>> src/midi_channel_controller.sv
// a message passes through the exec, mul, writeback and done states after its transaction;
// reset all controllers instead steps through walk, mul and writeback for each channel in turn
// the result is loaded in done once the output register is free; only then is a new message taken in idle
// a finished result waits in the output register while the next message is taken
// reset: synchronous; all channel stores return to defaults in the same cycle
module midi_channel_controller #(
  parameter int NUM_CHANNELS = 16
) (
  input logic      clk,
  input logic      rst,
  mcc_msg_if.sink  msg,
  mcc_res_if.source res
);

  mcc_pkg::dp_cmd_t    cmd;
  mcc_pkg::dp_status_t status;

  mcc_ctrl #(.NUM_CHANNELS(NUM_CHANNELS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mcc_dp #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_command       (msg.command),
    .in_channel       (msg.channel),
    .in_d1            (msg.data_msb),
    .in_d2            (msg.data_lsb),
    .out_channel      (res.out_channel),
    .level            (res.level),
    .pitch_offset     (res.pitch_offset),
    .program_number   (res.program_number),
    .bank_number      (res.bank_number),
    .program_changed  (res.program_changed),
    .chip_param_valid (res.chip_param_valid),
    .chip_param_type  (res.chip_param_type),
    .chip_param_value (res.chip_param_value)
  );

endmodule

>>> src/mcc_checker.sv
// port-level checks for midi_channel_controller
// bound to the top level; depends on nothing else
module mcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  level,
  input logic        program_changed,
  input logic        chip_param_valid,
  input logic [13:0] chip_param_type,
  input logic [13:0] chip_param_value
);

  // one message at a time in the sequencer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("message taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(level)))
    else $error("result dropped while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= 8'd128))
    else $error("level above full scale");

  a_fwd_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !chip_param_valid) |-> (chip_param_type == 14'd0 && chip_param_value == 14'd0))
    else $error("forwarded parameter fields not cleared");

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({program_changed, chip_param_valid}))
    else $error("program change and parameter forward in one transaction");

endmodule

bind midi_channel_controller mcc_checker u_mcc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (msg.valid),
  .in_ready         (msg.ready),
  .out_valid        (res.valid),
  .out_ready        (res.ready),
  .level            (res.level),
  .program_changed  (res.program_changed),
  .chip_param_valid (res.chip_param_valid),
  .chip_param_type  (res.chip_param_type),
  .chip_param_value (res.chip_param_value)
);

>>> tb/midi_channel_controller_tb.sv
// testbench for midi_channel_controller: directed and random controller messages,
// each result checked against a per-channel predictor kept in the testbench
// depends on mcc_pkg, mcc_msg_if, mcc_res_if and the controller rtl
module midi_channel_controller_tb;

  localparam logic [3:0] CMD_UNUSED = 4'd15;
  localparam int NCH = 16;
  localparam int WHEEL_MID = 8192;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 550;

  typedef struct {
    logic [3:0]         out_channel;
    logic [7:0]         level;
    logic signed [15:0] pitch_offset;
    logic [6:0]         program_number;
    logic [13:0]        bank_number;
    logic               program_changed;
    logic               chip_param_valid;
    logic [13:0]        chip_param_type;
    logic [13:0]        chip_param_value;
  } channel_report_t;

  logic clk = 0;
  logic rst = 1;

  mcc_msg_if msg_ch ();
  mcc_res_if res_ch ();

  midi_channel_controller #(.NUM_CHANNELS(NCH)) uut (
    .clk(clk),
    .rst(rst),
    .msg(msg_ch),
    .res(res_ch)
  );

  always #2 clk = ~clk;

  // channel state mirrored from the message stream
  int prog_st[NCH], bank_st[NCH], rpn_st[NCH], nrpn_st[NCH], entry_st[NCH];
  int vol_st[NCH], expr_st[NCH], level_st[NCH], wheel_st[NCH], coarse_st[NCH];
  int fine_st[NCH], pitch_st[NCH], range_st[NCH], ivol_st[NCH], icoarse_st[NCH];
  int ifine_st[NCH];

  channel_report_t pending_reports[$];
  int err_count = 0;
  int sent_count = 0;
  int report_count = 0;
  int fwd_count = 0;
  int reset_all_count = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  int hold_req = 0;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int swap7(int v);
    return ((v & 'h7F) << 7) | ((v >> 7) & 'h7F);
  endfunction

  function automatic void clear_channels();
    for (int c = 0; c < NCH; c++) begin
      prog_st[c] = 0; bank_st[c] = 0;
      rpn_st[c] = mcc_pkg::NULL_NUMBER; nrpn_st[c] = mcc_pkg::NULL_NUMBER;
      entry_st[c] = 0; vol_st[c] = 128; expr_st[c] = 128; level_st[c] = 128;
      wheel_st[c] = 0; coarse_st[c] = 0; fine_st[c] = 0; pitch_st[c] = 0;
      range_st[c] = mcc_pkg::RANGE_DEFAULT; ivol_st[c] = mcc_pkg::FULL_SCALE;
      icoarse_st[c] = 0; ifine_st[c] = 0;
    end
  endfunction

  function automatic void update_level(int c);
    level_st[c] = ((((vol_st[c] * expr_st[c]) >> 7) * ivol_st[c]) >> 7) & 'hFF;
  endfunction

  function automatic void update_pitch(int c);
    int acc;
    acc = ((wheel_st[c] * range_st[c]) >>> 13) + coarse_st[c] * 128 + (fine_st[c] >>> 6)
        + icoarse_st[c] * 128 + (ifine_st[c] >>> 6);
    pitch_st[c] = acc & 'hFFFF;
  endfunction

  function automatic void set_range(int c, int v);
    if (range_st[c] != v) begin
      range_st[c] = v;
      update_pitch(c);
    end
  endfunction

  function automatic void set_expr(int c, int v);
    if (expr_st[c] != v) begin
      expr_st[c] = v ? v + 1 : 0;
      update_level(c);
    end
  endfunction

  function automatic void set_wheel(int c, int hi, int lo);
    int x;
    x = ((hi << 7) | lo) - WHEEL_MID;
    if (x > 0) x++;
    wheel_st[c] = x;
    update_pitch(c);
  endfunction

  // data entry onto the selected parameter; bytes are swapped except for coarse/volume and forwarded values
  function automatic void apply_entry(int c, ref channel_report_t rep);
    int v, x;
    v = entry_st[c];
    if (rpn_st[c] != mcc_pkg::NULL_NUMBER) begin
      if (rpn_st[c] == mcc_pkg::RPN_RANGE) set_range(c, swap7(v));
      else if (rpn_st[c] == mcc_pkg::RPN_FINE) begin
        x = swap7(v) - WHEEL_MID;
        if (x > 0) x++;
        fine_st[c] = x;
        update_pitch(c);
      end else if (rpn_st[c] == mcc_pkg::RPN_COARSE) begin
        coarse_st[c] = (v >> 7) - 'h40;
        update_pitch(c);
      end
    end else if (nrpn_st[c] != mcc_pkg::NULL_NUMBER) begin
      if (nrpn_st[c] == mcc_pkg::NRPN_RANGE) set_range(c, swap7(v));
      else if (nrpn_st[c] == mcc_pkg::NRPN_VOLUME) begin
        x = v >> 7;
        if (x != 0) x++;
        if (ivol_st[c] != x) begin
          ivol_st[c] = x;
          update_level(c);
        end
      end else if (nrpn_st[c] == mcc_pkg::NRPN_FINE) begin
        x = swap7(v) - WHEEL_MID;
        if (x != 0) x++;
        if (ifine_st[c] != x) begin
          ifine_st[c] = x;
          update_pitch(c);
        end
      end else if (nrpn_st[c] == mcc_pkg::NRPN_COARSE) begin
        x = (v >> 7) - 'h40;
        if (icoarse_st[c] != x) begin
          icoarse_st[c] = x;
          update_pitch(c);
        end
      end else begin
        rep.chip_param_valid = 1;
        rep.chip_param_type = nrpn_st[c];
        rep.chip_param_value = v;
      end
    end
  endfunction

  function automatic channel_report_t predict_report(logic [3:0] cmd, int c, int d1, int d2);
    channel_report_t rep;
    rep.program_changed = 0;
    rep.chip_param_valid = 0;
    rep.chip_param_type = 0;
    rep.chip_param_value = 0;
    case (cmd)
      mcc_pkg::CMD_RESET_ALL: begin
        for (int i = 0; i < NCH; i++) begin
          set_expr(i, mcc_pkg::EXPR_RESET);
          set_wheel(i, 'h40, 0);
          rpn_st[i] = mcc_pkg::NULL_NUMBER;
          nrpn_st[i] = mcc_pkg::NULL_NUMBER;
        end
      end
      mcc_pkg::CMD_PROGRAM: begin
        if (prog_st[c] != d1) begin
          prog_st[c] = d1;
          range_st[c] = mcc_pkg::RANGE_DEFAULT;
          ivol_st[c] = mcc_pkg::FULL_SCALE;
          icoarse_st[c] = 0;
          ifine_st[c] = 0;
          rep.program_changed = 1;
        end
      end
      mcc_pkg::CMD_VOLUME: begin
        if (vol_st[c] != d1) begin
          vol_st[c] = d1 ? d1 + 1 : 0;
          update_level(c);
        end
      end
      mcc_pkg::CMD_EXPRESSION: set_expr(c, d1);
      mcc_pkg::CMD_PITCHWHEEL: set_wheel(c, d1, d2);
      mcc_pkg::CMD_BANK_LSB: bank_st[c] = (bank_st[c] & 'h3F80) | d1;
      mcc_pkg::CMD_BANK_MSB: bank_st[c] = (bank_st[c] & 'h7F) | (d1 << 7);
      mcc_pkg::CMD_DATA_LSB: begin
        entry_st[c] = (entry_st[c] & 'h3F80) | d1;
        apply_entry(c, rep);
      end
      mcc_pkg::CMD_DATA_MSB: begin
        entry_st[c] = (entry_st[c] & 'h7F) | (d1 << 7);
        apply_entry(c, rep);
      end
      mcc_pkg::CMD_DATA_INC: begin
        if (entry_st[c] < mcc_pkg::NULL_NUMBER) entry_st[c]++;
        apply_entry(c, rep);
      end
      mcc_pkg::CMD_DATA_DEC: begin
        if (entry_st[c] > 0) entry_st[c]--;
        apply_entry(c, rep);
      end
      mcc_pkg::CMD_NRPN_LSB: begin
        rpn_st[c] = mcc_pkg::NULL_NUMBER;
        nrpn_st[c] = (nrpn_st[c] & 'h3F80) | d1;
      end
      mcc_pkg::CMD_NRPN_MSB: begin
        rpn_st[c] = mcc_pkg::NULL_NUMBER;
        nrpn_st[c] = (nrpn_st[c] & 'h7F) | (d1 << 7);
      end
      mcc_pkg::CMD_RPN_LSB: begin
        nrpn_st[c] = mcc_pkg::NULL_NUMBER;
        rpn_st[c] = (rpn_st[c] & 'h3F80) | d1;
      end
      mcc_pkg::CMD_RPN_MSB: begin
        nrpn_st[c] = mcc_pkg::NULL_NUMBER;
        rpn_st[c] = (rpn_st[c] & 'h7F) | (d1 << 7);
      end
      default: ;
    endcase
    rep.out_channel = c;
    rep.level = level_st[c];
    rep.pitch_offset = pitch_st[c];
    rep.program_number = prog_st[c];
    rep.bank_number = bank_st[c];
    return rep;
  endfunction

  // one message transaction; prediction is made at the accepting edge
  task automatic send_msg(logic [3:0] cmd, int c, int d1, int d2);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      msg_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    msg_ch.valid <= 1;
    msg_ch.command <= cmd;
    msg_ch.channel <= c;
    msg_ch.data_msb <= d1;
    msg_ch.data_lsb <= d2;
    do @(posedge clk); while (!msg_ch.ready);
    pending_reports.push_back(predict_report(cmd, c, d1, d2));
    sent_count++;
    if (cmd == mcc_pkg::CMD_RESET_ALL) reset_all_count++;
  endtask

  task automatic select_param(bit registered, int c, int num);
    send_msg(registered ? mcc_pkg::CMD_RPN_MSB : mcc_pkg::CMD_NRPN_MSB, c,
             (num >> 7) & 'h7F, 0);
    send_msg(registered ? mcc_pkg::CMD_RPN_LSB : mcc_pkg::CMD_NRPN_LSB, c, num & 'h7F, 0);
  endtask

  task automatic test_defaults_and_levels();
    send_msg(CMD_UNUSED, 0, 127, 127);
    send_msg(mcc_pkg::CMD_VOLUME, 1, 0, 0);
    send_msg(mcc_pkg::CMD_VOLUME, 1, 127, 0);
    send_msg(mcc_pkg::CMD_VOLUME, 1, 127, 0);
    send_msg(mcc_pkg::CMD_EXPRESSION, 1, 64, 0);
    send_msg(mcc_pkg::CMD_PITCHWHEEL, 2, 0, 0);
    send_msg(mcc_pkg::CMD_PITCHWHEEL, 2, 127, 127);
    send_msg(mcc_pkg::CMD_BANK_MSB, 15, 127, 0);
    send_msg(mcc_pkg::CMD_BANK_LSB, 15, 85, 0);
    send_msg(mcc_pkg::CMD_PROGRAM, 15, 127, 0);
  endtask

  task automatic test_param_entry();
    select_param(1, 3, mcc_pkg::RPN_RANGE);
    send_msg(mcc_pkg::CMD_DATA_MSB, 3, 5, 0);
    select_param(1, 3, mcc_pkg::RPN_FINE);
    send_msg(mcc_pkg::CMD_DATA_LSB, 3, 127, 0);
    select_param(0, 4, mcc_pkg::NRPN_VOLUME);
    send_msg(mcc_pkg::CMD_DATA_MSB, 4, 0, 0);
    // unknown nrpn goes out as a chip parameter
    select_param(0, 5, 'h3FFE);
    send_msg(mcc_pkg::CMD_DATA_LSB, 5, 127, 0);
    send_msg(mcc_pkg::CMD_DATA_MSB, 5, 127, 0);
    send_msg(mcc_pkg::CMD_DATA_INC, 5, 0, 0);
    send_msg(mcc_pkg::CMD_DATA_DEC, 6, 0, 0);
    send_msg(mcc_pkg::CMD_RESET_ALL, 7, 0, 0);
  endtask

  task automatic test_random_traffic();
    int c, k, num, pick;
    bit reg_sel;
    while (sent_count < RANDOM_ITEMS + 30) begin
      quiet = ($urandom_range(0, 19) == 0) ? !quiet : quiet;
      c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3);
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 7);
        reg_sel = pick < 3;
        case (pick)
          0: num = mcc_pkg::RPN_RANGE;
          1: num = mcc_pkg::RPN_FINE;
          2: num = mcc_pkg::RPN_COARSE;
          3: num = mcc_pkg::NRPN_RANGE;
          4: num = mcc_pkg::NRPN_VOLUME;
          5: num = mcc_pkg::NRPN_FINE;
          6: num = mcc_pkg::NRPN_COARSE;
          default: num = $urandom_range(0, 16383);
        endcase
        select_param(reg_sel, c, num);
        k = $urandom_range(1, 3);
        repeat (k) begin
          case ($urandom_range(0, 3))
            0: send_msg(mcc_pkg::CMD_DATA_MSB, c, $urandom_range(0, 127),
                        $urandom_range(0, 127));
            1: send_msg(mcc_pkg::CMD_DATA_LSB, c, $urandom_range(0, 127),
                        $urandom_range(0, 127));
            2: send_msg(mcc_pkg::CMD_DATA_INC, c, $urandom_range(0, 127), 0);
            default: send_msg(mcc_pkg::CMD_DATA_DEC, c, $urandom_range(0, 127), 0);
          endcase
        end
      end else begin
        pick = $urandom_range(0, 15);
        if (pick == mcc_pkg::CMD_RESET_ALL && $urandom_range(0, 3) != 0)
          pick = mcc_pkg::CMD_PITCHWHEEL;
        send_msg(pick, c, $urandom_range(0, 127), $urandom_range(0, 127));
      end
    end
    quiet = 0;
  endtask

  // receiver holds off while messages keep coming so the block backs up
  task automatic test_backpressure();
    hold_req = 60;
    quiet = 1;
    for (int i = 0; i < 20; i++)
      send_msg($urandom_range(0, 13), $urandom_range(0, 15), $urandom_range(0, 127),
               $urandom_range(0, 127));
    quiet = 0;
  endtask

  // result side: random stalls, long hold-offs on request
  initial begin
    int stall_left;
    stall_left = 0;
    res_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 0;
        stall_left--;
      end else begin
        res_ch.ready <= 1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    channel_report_t exp_rep;
    if (!rst && res_ch.valid && res_ch.ready) begin
      report_count++;
      if (res_ch.chip_param_valid) fwd_count++;
      if (pending_reports.size() == 0) begin
        $error("result with no pending message, channel %0d", res_ch.out_channel);
        err_count++;
      end else begin
        exp_rep = pending_reports.pop_front();
        if (res_ch.out_channel !== exp_rep.out_channel) begin
          $error("out_channel exp %0d got %0d", exp_rep.out_channel, res_ch.out_channel);
          err_count++;
        end
        if (res_ch.level !== exp_rep.level) begin
          $error("level exp %0d got %0d", exp_rep.level, res_ch.level);
          err_count++;
        end
        if (res_ch.pitch_offset !== exp_rep.pitch_offset) begin
          $error("pitch_offset exp %0d got %0d", exp_rep.pitch_offset, res_ch.pitch_offset);
          err_count++;
        end
        if (res_ch.program_number !== exp_rep.program_number) begin
          $error("program_number exp %0d got %0d", exp_rep.program_number,
                 res_ch.program_number);
          err_count++;
        end
        if (res_ch.bank_number !== exp_rep.bank_number) begin
          $error("bank_number exp %0d got %0d", exp_rep.bank_number, res_ch.bank_number);
          err_count++;
        end
        if (res_ch.program_changed !== exp_rep.program_changed) begin
          $error("program_changed exp %0d got %0d", exp_rep.program_changed,
                 res_ch.program_changed);
          err_count++;
        end
        if (res_ch.chip_param_valid !== exp_rep.chip_param_valid) begin
          $error("chip_param_valid exp %0d got %0d", exp_rep.chip_param_valid,
                 res_ch.chip_param_valid);
          err_count++;
        end
        if (res_ch.chip_param_type !== exp_rep.chip_param_type) begin
          $error("chip_param_type exp %0d got %0d", exp_rep.chip_param_type,
                 res_ch.chip_param_type);
          err_count++;
        end
        if (res_ch.chip_param_value !== exp_rep.chip_param_value) begin
          $error("chip_param_value exp %0d got %0d", exp_rep.chip_param_value,
                 res_ch.chip_param_value);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    msg_ch.valid = 0;
    msg_ch.command = CMD_UNUSED;
    msg_ch.channel = 0;
    msg_ch.data_msb = 0;
    msg_ch.data_lsb = 0;
    clear_channels();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_defaults_and_levels();
    test_param_entry();
    test_backpressure();
    test_random_traffic();
    @(negedge clk);
    msg_ch.valid <= 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending_reports.size() != 0) err_count++;
    $display("covered %0d messages, %0d results, %0d reset-all, %0d forwarded nrpn",
             sent_count, report_count, reset_all_count, fwd_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
